[hdl/caf_pkg.sv]
// Package for the 8-bit CPU arithmetic unit with flags.
// Holds the operation codes and the flag bit layout; no dependencies.

package caf_pkg;

    typedef enum logic [4:0] {
        OP_ADD   = 5'd0,
        OP_ADC   = 5'd1,
        OP_SUB   = 5'd2,
        OP_SBC   = 5'd3,
        OP_AND   = 5'd4,
        OP_XOR   = 5'd5,
        OP_OR    = 5'd6,
        OP_CP    = 5'd7,
        OP_INC8  = 5'd8,
        OP_DEC8  = 5'd9,
        OP_RLC   = 5'd10,
        OP_RRC   = 5'd11,
        OP_RL    = 5'd12,
        OP_RR    = 5'd13,
        OP_SLA   = 5'd14,
        OP_SRA   = 5'd15,
        OP_SWAP  = 5'd16,
        OP_SRL   = 5'd17,
        OP_BIT   = 5'd18,
        OP_RES   = 5'd19,
        OP_SET   = 5'd20,
        OP_DAA   = 5'd21,
        OP_CPL   = 5'd22,
        OP_SCF   = 5'd23,
        OP_CCF   = 5'd24,
        OP_ADD16 = 5'd25,
        OP_ADDSP = 5'd26,
        OP_INC16 = 5'd27,
        OP_DEC16 = 5'd28
    } op_t;

    // Flag register layout.
    localparam int FLAG_Z = 3;
    localparam int FLAG_N = 2;
    localparam int FLAG_H = 1;
    localparam int FLAG_C = 0;

    localparam logic [3:0] FLAGS_RESET = 4'b1011;

    typedef logic [3:0] flags_t;

endpackage

[hdl/cpu_alu_with_flags_top.sv]
// 8-bit CPU arithmetic unit with a kept flag register.
// Each beat passes the input register, then the result register; one beat per cycle
// unless m_ready stalls the output. The flag register feeds the next beat directly.
// Reset (aresetn, synchronous, active low) empties both stages and sets
// the flags to zero, half carry and carry.
// Depends on caf_pkg.

module cpu_alu_with_flags_top
    import caf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [4:0]  s_action,
    input  logic [15:0] s_operand_a,
    input  logic [15:0] s_operand_b,
    input  logic [2:0]  s_bit_index,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_result,
    output logic [3:0]  m_flags_out
);

    logic        in_valid_reg;
    logic [4:0]  action_reg;
    logic [15:0] opa_reg;
    logic [15:0] opb_reg;
    logic [2:0]  bit_index_reg;

    logic        out_valid_reg;
    logic [15:0] result_reg;
    flags_t      flags_out_reg;
    flags_t      flag_reg;

    logic        advance;
    logic [15:0] result_next;
    flags_t      flag_next;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            flag_reg      <= FLAGS_RESET;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                flag_reg      <= flag_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            action_reg    <= s_action;
            opa_reg       <= s_operand_a;
            opb_reg       <= s_operand_b;
            bit_index_reg <= s_bit_index;
        end
        if (advance) begin
            result_reg    <= result_next;
            flags_out_reg <= flag_next;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_result    = result_reg;
    assign m_flags_out = flags_out_reg;

    // Operation datapath.
    logic [7:0]  a;
    logic [7:0]  b;
    logic        ck;
    logic        cin;
    logic [8:0]  sum9;
    logic [4:0]  hsum5;
    logic [8:0]  diff9;
    logic [4:0]  hdiff5;
    logic [7:0]  r8;
    logic [7:0]  daa_r;
    logic        daa_c;
    logic [7:0]  bit_mask;
    logic [16:0] sum17;
    logic [12:0] hsum13;
    logic [15:0] sp_sum;

    always_comb begin
        a        = opa_reg[7:0];
        b        = opb_reg[7:0];
        ck       = flag_reg[FLAG_C];
        cin      = (action_reg == OP_ADC || action_reg == OP_SBC) ? ck : 1'b0;
        sum9     = {1'b0, a} + {1'b0, b} + {8'd0, cin};
        hsum5    = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cin};
        diff9    = {1'b0, a} - {1'b0, b} - {8'd0, cin};
        hdiff5   = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, cin};
        bit_mask = 8'd1 << bit_index_reg;
        sum17    = {1'b0, opa_reg} + {1'b0, opb_reg};
        hsum13   = {1'b0, opa_reg[11:0]} + {1'b0, opb_reg[11:0]};
        sp_sum   = opa_reg + {{8{b[7]}}, b};

        // Decimal adjust, steered by the incoming subtract/half/carry flags.
        daa_r = a;
        daa_c = ck;
        if (flag_reg[FLAG_N]) begin
            if (ck) begin
                daa_r = daa_r - 8'h60;
            end
            if (flag_reg[FLAG_H]) begin
                daa_r = daa_r - 8'h06;
            end
        end else begin
            if (ck || a > 8'h99) begin
                daa_r = daa_r + 8'h60;
                daa_c = 1'b1;
            end
            if (flag_reg[FLAG_H] || a[3:0] > 4'h9) begin
                daa_r = daa_r + 8'h06;
            end
        end

        r8          = 8'd0;
        result_next = opa_reg;
        flag_next   = flag_reg;
        unique case (action_reg)
            OP_ADD, OP_ADC: begin
                r8          = sum9[7:0];
                result_next = {8'd0, r8};
                flag_next   = {r8 == 8'd0, 1'b0, hsum5[4], sum9[8]};
            end
            OP_SUB, OP_SBC, OP_CP: begin
                r8          = diff9[7:0];
                result_next = (action_reg == OP_CP) ? opa_reg : {8'd0, r8};
                flag_next   = {r8 == 8'd0, 1'b1, hdiff5[4], diff9[8]};
            end
            OP_AND: begin
                r8          = a & b;
                result_next = {8'd0, r8};
                flag_next   = {r8 == 8'd0, 1'b0, 1'b1, 1'b0};
            end
            OP_XOR: begin
                r8          = a ^ b;
                result_next = {8'd0, r8};
                flag_next   = {r8 == 8'd0, 3'b000};
            end
            OP_OR: begin
                r8          = a | b;
                result_next = {8'd0, r8};
                flag_next   = {r8 == 8'd0, 3'b000};
            end
            OP_INC8: begin
                r8          = a + 8'd1;
                result_next = {8'd0, r8};
                flag_next   = {r8 == 8'd0, 1'b0, a[3:0] == 4'hf, ck};
            end
            OP_DEC8: begin
                r8          = a - 8'd1;
                result_next = {8'd0, r8};
                flag_next   = {r8 == 8'd0, 1'b1, a[3:0] == 4'h0, ck};
            end
            OP_RLC: begin
                r8          = {a[6:0], a[7]};
                result_next = {8'd0, r8};
                flag_next   = {r8 == 8'd0, 2'b00, a[7]};
            end
            OP_RRC: begin
                r8          = {a[0], a[7:1]};
                result_next = {8'd0, r8};
                flag_next   = {r8 == 8'd0, 2'b00, a[0]};
            end
            OP_RL: begin
                r8          = {a[6:0], ck};
                result_next = {8'd0, r8};
                flag_next   = {r8 == 8'd0, 2'b00, a[7]};
            end
            OP_RR: begin
                r8          = {ck, a[7:1]};
                result_next = {8'd0, r8};
                flag_next   = {r8 == 8'd0, 2'b00, a[0]};
            end
            OP_SLA: begin
                r8          = {a[6:0], 1'b0};
                result_next = {8'd0, r8};
                flag_next   = {r8 == 8'd0, 2'b00, a[7]};
            end
            OP_SRA: begin
                r8          = {a[7], a[7:1]};
                result_next = {8'd0, r8};
                flag_next   = {r8 == 8'd0, 2'b00, a[0]};
            end
            OP_SWAP: begin
                r8          = {a[3:0], a[7:4]};
                result_next = {8'd0, r8};
                flag_next   = {r8 == 8'd0, 3'b000};
            end
            OP_SRL: begin
                r8          = {1'b0, a[7:1]};
                result_next = {8'd0, r8};
                flag_next   = {r8 == 8'd0, 2'b00, a[0]};
            end
            OP_BIT: begin
                result_next = opa_reg;
                flag_next   = {(a & bit_mask) == 8'd0, 1'b0, 1'b1, ck};
            end
            OP_RES: begin
                result_next = {8'd0, a & ~bit_mask};
            end
            OP_SET: begin
                result_next = {8'd0, a | bit_mask};
            end
            OP_DAA: begin
                result_next = {8'd0, daa_r};
                flag_next   = {daa_r == 8'd0, flag_reg[FLAG_N], 1'b0, daa_c};
            end
            OP_CPL: begin
                result_next = {8'd0, ~a};
                flag_next   = {flag_reg[FLAG_Z], 1'b1, 1'b1, ck};
            end
            OP_SCF: begin
                result_next = {8'd0, a};
                flag_next   = {flag_reg[FLAG_Z], 1'b0, 1'b0, 1'b1};
            end
            OP_CCF: begin
                result_next = {8'd0, a};
                flag_next   = {flag_reg[FLAG_Z], 1'b0, 1'b0, !ck};
            end
            OP_ADD16: begin
                result_next = sum17[15:0];
                flag_next   = {flag_reg[FLAG_Z], 1'b0, hsum13[12], sum17[16]};
            end
            OP_ADDSP: begin
                // Flags come from the unsigned low-byte add even though b is signed.
                result_next = sp_sum;
                flag_next   = {1'b0, 1'b0, hsum5[4], sum9[8]};
            end
            OP_INC16: begin
                result_next = opa_reg + 16'd1;
            end
            OP_DEC16: begin
                result_next = opa_reg - 16'd1;
            end
            default: begin
                result_next = opa_reg;
                flag_next   = flag_reg;
            end
        endcase
    end

endmodule

[tb/cpu_alu_with_flags_top_tb.sv]
// Self-checking testbench for cpu_alu_with_flags_top: directed ops, then random ops with random gaps
// and result back-pressure, checked against an in-bench model of the ALU and its flags.
// Depends on caf_pkg and the RTL of cpu_alu_with_flags_top.
`timescale 1ns / 100ps

module cpu_alu_with_flags_top_tb;
    import caf_pkg::*;

    localparam int RANDOM_OPS = 2000;

    typedef struct {
        logic [4:0]  action;
        logic [15:0] result;
        flags_t      flags;
    } alu_outcome_t;

    class alu_flag_scoreboard;
        flags_t       flag_reg;
        alu_outcome_t alu_outcomes[$];
        int           mismatches;

        function new();
            flag_reg   = FLAGS_RESET;
            mismatches = 0;
        endfunction

        task report(string msg);
            mismatches++;
            $display("ERROR at %0t ns: %s", $time, msg);
        endtask

        // Works out the result and next flags of one operation; the flag image
        // is {zero, subtract, half carry, carry}.
        function alu_outcome_t compute_alu(logic [4:0] act, logic [15:0] a16,
                                           logic [15:0] b16, logic [2:0] idx);
            alu_outcome_t o;
            logic [7:0]   a;
            logic [7:0]   b;
            logic [7:0]   r8;
            logic [8:0]   sum9;
            logic [4:0]   sum5;
            logic [16:0]  sum17;
            logic [12:0]  sum13;
            logic         cin;
            logic         zk;
            logic         nk;
            logic         hk;
            logic         c_new;
            logic         narrow;
            flags_t       f;
            a        = a16[7:0];
            b        = b16[7:0];
            f        = flag_reg;
            cin      = f[FLAG_C];
            zk       = f[FLAG_Z];
            nk       = f[FLAG_N];
            hk       = f[FLAG_H];
            r8       = a;
            narrow   = 1'b1;
            o.result = a16;
            case (act)
                OP_ADD, OP_ADC: begin
                    c_new = (act == OP_ADC) ? cin : 1'b0;
                    sum9  = {1'b0, a} + {1'b0, b} + {8'd0, c_new};
                    sum5  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, c_new};
                    r8    = sum9[7:0];
                    f     = {r8 == 8'h00, 1'b0, sum5[4], sum9[8]};
                end
                OP_SUB, OP_SBC, OP_CP: begin
                    c_new = (act == OP_SBC) ? cin : 1'b0;
                    sum9  = {1'b0, b} + {8'd0, c_new};
                    sum5  = {1'b0, b[3:0]} + {4'd0, c_new};
                    r8    = a - b - {7'd0, c_new};
                    f     = {r8 == 8'h00, 1'b1, {1'b0, a[3:0]} < sum5, {1'b0, a} < sum9};
                    // Compare only sets flags; the operand passes through whole.
                    if (act == OP_CP) narrow = 1'b0;
                end
                OP_AND: begin
                    r8 = a & b;
                    f  = {r8 == 8'h00, 1'b0, 1'b1, 1'b0};
                end
                OP_XOR: begin
                    r8 = a ^ b;
                    f  = {r8 == 8'h00, 3'b000};
                end
                OP_OR: begin
                    r8 = a | b;
                    f  = {r8 == 8'h00, 3'b000};
                end
                OP_INC8: begin
                    r8 = a + 8'd1;
                    f  = {r8 == 8'h00, 1'b0, a[3:0] == 4'hf, cin};
                end
                OP_DEC8: begin
                    r8 = a - 8'd1;
                    f  = {r8 == 8'h00, 1'b1, a[3:0] == 4'h0, cin};
                end
                OP_RLC: begin
                    r8 = {a[6:0], a[7]};
                    f  = {r8 == 8'h00, 2'b00, a[7]};
                end
                OP_RRC: begin
                    r8 = {a[0], a[7:1]};
                    f  = {r8 == 8'h00, 2'b00, a[0]};
                end
                OP_RL: begin
                    r8 = {a[6:0], cin};
                    f  = {r8 == 8'h00, 2'b00, a[7]};
                end
                OP_RR: begin
                    r8 = {cin, a[7:1]};
                    f  = {r8 == 8'h00, 2'b00, a[0]};
                end
                OP_SLA: begin
                    r8 = {a[6:0], 1'b0};
                    f  = {r8 == 8'h00, 2'b00, a[7]};
                end
                OP_SRA: begin
                    r8 = {a[7], a[7:1]};
                    f  = {r8 == 8'h00, 2'b00, a[0]};
                end
                OP_SWAP: begin
                    r8 = {a[3:0], a[7:4]};
                    f  = {r8 == 8'h00, 3'b000};
                end
                OP_SRL: begin
                    r8 = {1'b0, a[7:1]};
                    f  = {r8 == 8'h00, 2'b00, a[0]};
                end
                OP_BIT: begin
                    narrow = 1'b0;
                    f      = {~a[idx], 1'b0, 1'b1, cin};
                end
                OP_RES: r8 = a & ~(8'h01 << idx);
                OP_SET: r8 = a | (8'h01 << idx);
                OP_DAA: begin
                    c_new = cin;
                    if (nk) begin
                        if (cin) r8 = r8 - 8'h60;
                        if (hk) r8 = r8 - 8'h06;
                    end else begin
                        if (cin || a > 8'h99) begin
                            r8    = r8 + 8'h60;
                            c_new = 1'b1;
                        end
                        if (hk || a[3:0] > 4'd9) r8 = r8 + 8'h06;
                    end
                    f = {r8 == 8'h00, nk, 1'b0, c_new};
                end
                OP_CPL: begin
                    r8 = ~a;
                    f  = {zk, 1'b1, 1'b1, cin};
                end
                OP_SCF: f = {zk, 2'b00, 1'b1};
                OP_CCF: f = {zk, 2'b00, ~cin};
                OP_ADD16: begin
                    narrow   = 1'b0;
                    sum17    = {1'b0, a16} + {1'b0, b16};
                    sum13    = {1'b0, a16[11:0]} + {1'b0, b16[11:0]};
                    o.result = sum17[15:0];
                    f        = {zk, 1'b0, sum13[12], sum17[16]};
                end
                OP_ADDSP: begin
                    // Flags come from the unsigned low-byte add, the sum is signed.
                    narrow   = 1'b0;
                    sum9     = {1'b0, a} + {1'b0, b};
                    sum5     = {1'b0, a[3:0]} + {1'b0, b[3:0]};
                    o.result = a16 + {{8{b[7]}}, b};
                    f        = {2'b00, sum5[4], sum9[8]};
                end
                OP_INC16: begin
                    narrow   = 1'b0;
                    o.result = a16 + 16'd1;
                end
                OP_DEC16: begin
                    narrow   = 1'b0;
                    o.result = a16 - 16'd1;
                end
                default: narrow = 1'b0;
            endcase
            if (narrow) o.result = {8'h00, r8};
            o.action = act;
            o.flags  = f;
            flag_reg = f;
            return o;
        endfunction

        task note_input(logic [4:0] act, logic [15:0] a16, logic [15:0] b16,
                        logic [2:0] idx);
            alu_outcomes.push_back(compute_alu(act, a16, b16, idx));
        endtask

        task check_result(logic [15:0] result, logic [3:0] flags);
            alu_outcome_t o;
            if (alu_outcomes.size() == 0) begin
                report($sformatf("result beat %h/%h with nothing outstanding", result, flags));
            end else begin
                o = alu_outcomes.pop_front();
                if (result !== o.result)
                    report($sformatf("action %0d: result %h, expected %h",
                                     o.action, result, o.result));
                if (flags !== o.flags)
                    report($sformatf("action %0d: flags %b, expected %b",
                                     o.action, flags, o.flags));
            end
        endtask

        task check_drained();
            if (alu_outcomes.size() != 0)
                report($sformatf("%0d results never arrived", alu_outcomes.size()));
        endtask
    endclass

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    logic [4:0]  s_action    = '0;
    logic [15:0] s_operand_a = '0;
    logic [15:0] s_operand_b = '0;
    logic [2:0]  s_bit_index = '0;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    logic [15:0] m_result;
    logic [3:0]  m_flags_out;

    alu_flag_scoreboard sb = new();

    bit gapless_run  = 1'b0;
    bit ready_steady = 1'b0;
    int stall_left   = 0;
    int ready_cycles = 0;

    cpu_alu_with_flags_top dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_action    (s_action),
        .s_operand_a (s_operand_a),
        .s_operand_b (s_operand_b),
        .s_bit_index (s_bit_index),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_result    (m_result),
        .m_flags_out (m_flags_out)
    );

    always #1 aclk = ~aclk;

    // Beats are sampled at the edge, before any of this edge's updates land.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                sb.note_input(s_action, s_operand_a, s_operand_b, s_bit_index);
            if (m_valid && m_ready)
                sb.check_result(m_result, m_flags_out);
        end
    end

    // Result-side back-pressure, with occasional stretches of steady ready.
    always @(posedge aclk) begin
        ready_cycles++;
        if (ready_cycles % 150 == 0) ready_steady = ($urandom_range(0, 3) == 0);
        if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else begin
            m_ready <= 1'b1;
            if (!ready_steady && $urandom_range(0, 99) < 25)
                stall_left = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3)
                                                        : $urandom_range(4, 30);
        end
    end

    function int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (gapless_run || roll < 60) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 25);
    endfunction

    function logic [7:0] corner_byte();
        case ($urandom_range(0, 9))
            0: return 8'h00;
            1: return 8'h01;
            2: return 8'h0f;
            3: return 8'h10;
            4: return 8'h7f;
            5: return 8'h80;
            6: return 8'h99;
            7: return 8'h9a;
            8: return 8'hf0;
            default: return 8'hff;
        endcase
    endfunction

    function logic [15:0] random_operand();
        logic [15:0] v;
        v = 16'($urandom);
        if ($urandom_range(0, 3) == 0) v[7:0] = corner_byte();
        if ($urandom_range(0, 7) == 0) v[15:8] = corner_byte();
        return v;
    endfunction

    // Called at a clock edge; returns at the edge where the beat is taken.
    task send_op(logic [4:0] act, logic [15:0] a16, logic [15:0] b16, logic [2:0] idx);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_action    <= act;
        s_operand_a <= a16;
        s_operand_b <= b16;
        s_bit_index <= idx;
        s_valid     <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task run_directed();
        send_op(OP_ADD,   16'h12ff, 16'hff01, 3'd0);
        send_op(OP_ADC,   16'h000f, 16'h0000, 3'd0);
        send_op(OP_SUB,   16'h0000, 16'h0001, 3'd0);
        send_op(OP_SBC,   16'h0010, 16'h000f, 3'd0);
        send_op(OP_CP,    16'hab55, 16'h0055, 3'd0);
        send_op(OP_AND,   16'hfff0, 16'hff0f, 3'd0);
        send_op(OP_XOR,   16'h00ff, 16'h00ff, 3'd0);
        send_op(OP_OR,    16'hff00, 16'h00ff, 3'd0);
        send_op(OP_INC8,  16'h00ff, 16'h0000, 3'd0);
        send_op(OP_DEC8,  16'h0100, 16'h0000, 3'd0);
        send_op(OP_RLC,   16'h0080, 16'h0000, 3'd0);
        send_op(OP_RRC,   16'h0001, 16'h0000, 3'd0);
        send_op(OP_RL,    16'h0080, 16'h0000, 3'd0);
        send_op(OP_RR,    16'h0001, 16'h0000, 3'd0);
        send_op(OP_SLA,   16'h0080, 16'h0000, 3'd0);
        send_op(OP_SRA,   16'h0081, 16'h0000, 3'd0);
        send_op(OP_SWAP,  16'h00f0, 16'h0000, 3'd0);
        send_op(OP_SRL,   16'h0001, 16'h0000, 3'd0);
        send_op(OP_BIT,   16'hff7f, 16'h0000, 3'd7);
        send_op(OP_RES,   16'hffff, 16'h0000, 3'd0);
        send_op(OP_SET,   16'hff00, 16'h0000, 3'd7);
        // Decimal adjust after an add and after a subtract.
        send_op(OP_ADD,   16'h0099, 16'h0001, 3'd0);
        send_op(OP_DAA,   16'h009a, 16'h0000, 3'd0);
        send_op(OP_SUB,   16'h0010, 16'h0001, 3'd0);
        send_op(OP_DAA,   16'h000f, 16'h0000, 3'd0);
        send_op(OP_CPL,   16'h5a00, 16'h0000, 3'd0);
        send_op(OP_SCF,   16'hff3c, 16'h0000, 3'd0);
        send_op(OP_CCF,   16'hffc3, 16'h0000, 3'd0);
        send_op(OP_ADD16, 16'hffff, 16'h0001, 3'd0);
        send_op(OP_ADD16, 16'h0fff, 16'h0001, 3'd0);
        send_op(OP_ADDSP, 16'h00ff, 16'hff01, 3'd0);
        send_op(OP_ADDSP, 16'h1000, 16'h0080, 3'd0);
        send_op(OP_INC16, 16'hffff, 16'h0000, 3'd0);
        send_op(OP_DEC16, 16'h0000, 16'h0000, 3'd0);
        send_op(5'd29,    16'hbeef, 16'h1234, 3'd3);
        send_op(5'd31,    16'h0000, 16'hffff, 3'd7);
    endtask

    initial begin
        int waited;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        run_directed();
        for (int i = 0; i < RANDOM_OPS; i++) begin
            if (i % 100 == 0) gapless_run = ($urandom_range(0, 3) == 0);
            send_op(5'($urandom_range(0, 31)), random_operand(), random_operand(),
                    3'($urandom_range(0, 7)));
        end
        s_valid <= 1'b0;
        waited = 0;
        while (sb.alu_outcomes.size() > 0 && waited < 2000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (8) @(posedge aclk);
        sb.check_drained();
        if (sb.mismatches == 0)
            $display("PASS cpu_alu_with_flags_top");
        else
            $display("FAIL cpu_alu_with_flags_top");
        $finish;
    end

    initial begin
        #2000000;
        $display("FAIL cpu_alu_with_flags_top");
        $finish;
    end

endmodule

[cpu_alu_with_flags_top.f]
hdl/caf_pkg.sv
hdl/cpu_alu_with_flags_top.sv
tb/cpu_alu_with_flags_top_tb.sv
